### rtl/core/sgg_pkg.sv
// Package for the glitch glyph stream: geometry constants, generator constants,
// payload and queue types, state encoding and the replacement palette.
// No dependencies.
package sgg_pkg;

    localparam int ROWS   = 4;
    localparam int COLS   = 16;
    localparam int FRAMES = 8;

    localparam int CELLS_PER_FRAME  = ROWS * COLS;
    localparam int CELLS_PER_PERIOD = CELLS_PER_FRAME * FRAMES;
    localparam int POS_W  = (CELLS_PER_PERIOD > 1) ? $clog2(CELLS_PER_PERIOD) : 1;
    localparam int FPOS_W = (CELLS_PER_FRAME > 1) ? $clog2(CELLS_PER_FRAME) : 1;

    localparam logic [63:0] GOLDEN_STEP = 64'h9e3779b97f4a7c15;
    localparam logic [63:0] MIX_MUL_A   = 64'hbf58476d1ce4e5b9;
    localparam logic [63:0] MIX_MUL_B   = 64'h94d049bb133111eb;

    // remainder by 100, one byte per step: q = (x * 5243) >> 19 is exact for x < 25600
    localparam logic [6:0]  KEEP_LIMIT  = 7'd70;
    localparam logic [6:0]  KEEP_SCALE  = 7'd100;
    localparam logic [12:0] RECIP_MUL   = 13'd5243;
    localparam int          RECIP_SHIFT = 19;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 32;
    localparam logic [CFG_IDX_W-1:0] CFG_SEED_WORD   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_AGENT_INDEX = 1'b1;

    typedef struct packed {
        logic [7:0] clean_glyph;
        logic       restart;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_glyph;
        logic       glitched;
        logic       end_of_frame;
    } t_out_item;

    // one cell handed from the front to the mixer
    typedef struct packed {
        logic [63:0] counter;
        logic [7:0]  clean_glyph;
        logic        end_of_frame;
    } t_work;

    typedef enum logic [2:0] {
        MS_IDLE,
        MS_MUL,
        MS_SHIFT,
        MS_MOD,
        MS_DONE
    } t_mix_state;

    function automatic logic [7:0] palette(input logic [3:0] idx);
        logic [7:0] g;
        unique case (idx)
            4'd0:  g = 8'h40;  // @
            4'd1:  g = 8'h23;  // #
            4'd2:  g = 8'h25;  // %
            4'd3:  g = 8'h26;  // &
            4'd4:  g = 8'h3F;  // ?
            4'd5:  g = 8'h21;  // !
            4'd6:  g = 8'h2A;  // *
            4'd7:  g = 8'h3B;  // ;
            4'd8:  g = 8'h3A;  // :
            4'd9:  g = 8'h2B;  // +
            4'd10: g = 8'h3D;  // =
            4'd11: g = 8'h7E;  // ~
            4'd12: g = 8'h5E;  // ^
            4'd13: g = 8'h60;  // `
            4'd14: g = 8'h7C;  // |
            default: g = 8'h2F;  // /
        endcase
        return g;
    endfunction

endpackage

### rtl/core/sgg_queue.sv
// Short FIFO between the front (counter stepping) and the mixer.
// Depends on sgg_pkg.
module sgg_queue
    import sgg_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_work  i_wdata,
    input  logic   i_pop,
    output t_work  o_rdata,
    output logic   o_full,
    output logic   o_empty
);

    t_work                r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]    r_wptr;
    logic [QPTR_W-1:0]    r_rptr;
    logic [QPTR_W:0]      r_count;

    assign o_full  = (r_count == (QPTR_W+1)'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_rdata = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (i_pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
            unique case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

### rtl/core/sgg_front.sv
// Front end: configuration registers, cell position tracking and counter
// stepping; hands one work entry per accepted cell to the queue.
// Depends on sgg_pkg.
module sgg_front
    import sgg_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    input  logic                  i_valid,
    input  t_in_item              i_data,
    output logic                  o_stall,
    input  logic                  i_q_full,
    output logic                  o_push,
    output t_work                 o_work
);

    logic [31:0]       r_seed_word;
    logic [7:0]        r_agent_index;
    logic [63:0]       r_counter;
    logic [POS_W-1:0]  r_pos;
    logic [FPOS_W-1:0] r_fpos;

    logic [63:0]       start_value;
    logic [63:0]       base;
    logic [63:0]       stepped;
    logic [POS_W-1:0]  pos0;
    logic [FPOS_W-1:0] fpos0;
    logic              eof;
    logic              period_end;

    assign start_value = {r_seed_word, 24'd0, r_agent_index};
    assign base        = i_data.restart ? start_value : r_counter;
    assign pos0        = i_data.restart ? '0 : r_pos;
    assign fpos0       = i_data.restart ? '0 : r_fpos;
    assign stepped     = base + GOLDEN_STEP;
    assign eof         = (fpos0 == FPOS_W'(CELLS_PER_FRAME - 1));
    assign period_end  = (pos0 == POS_W'(CELLS_PER_PERIOD - 1));

    assign o_stall = i_q_full;
    assign o_push  = i_valid && !i_q_full;

    always_comb begin
        o_work.counter      = stepped;
        o_work.clean_glyph  = i_data.clean_glyph;
        o_work.end_of_frame = eof;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed_word   <= '0;
            r_agent_index <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_SEED_WORD:   r_seed_word   <= i_cfg_wdata;
                CFG_AGENT_INDEX: r_agent_index <= i_cfg_wdata[7:0];
                default:         r_seed_word   <= r_seed_word;
            endcase
        end
    end

    // the period wrap reloads from the registers as they stand at the last cell
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_counter <= '0;
            r_pos     <= '0;
            r_fpos    <= '0;
        end else if (o_push) begin
            if (period_end) begin
                r_counter <= start_value;
                r_pos     <= '0;
                r_fpos    <= '0;
            end else begin
                r_counter <= stepped;
                r_pos     <= pos0 + 1'b1;
                r_fpos    <= eof ? '0 : fpos0 + 1'b1;
            end
        end
    end

endmodule

### rtl/core/sgg_mix_back.sv
// Back end: splitmix64 finalizer on one shared 32x32 multiplier, a byte-serial
// remainder by 100, palette substitution and the output register.
// Depends on sgg_pkg.
module sgg_mix_back
    import sgg_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_q_empty,
    input  t_work     i_work,
    output logic      o_pop,
    output logic      o_valid,
    output t_out_item o_data,
    input  logic      i_stall
);

    t_mix_state  r_state;
    t_mix_state  n_state;

    logic [63:0] r_z;
    logic [63:0] r_acc;
    logic [63:0] r_v;
    logic [1:0]  r_step;
    logic        r_phase;
    logic [2:0]  r_mod_cnt;
    logic [6:0]  r_rem;
    logic [3:0]  r_pal;
    logic [7:0]  r_glyph;
    logic        r_eof;
    logic        r_out_vld;
    t_out_item   r_out;

    logic        load_out;
    logic [63:0] mul_k;
    logic [31:0] mul_a;
    logic [31:0] mul_b;
    logic [63:0] prod;
    logic [14:0] mod_x;
    logic [27:0] mod_prod;
    logic [7:0]  mod_q;
    logic [14:0] mod_r;
    logic        glitch;

    // 64x64 low product from three partial products over r_step 0..2
    assign mul_k = r_phase ? MIX_MUL_B : MIX_MUL_A;
    assign mul_a = (r_step == 2'd2) ? r_z[63:32] : r_z[31:0];
    assign mul_b = (r_step == 2'd1) ? mul_k[63:32] : mul_k[31:0];
    assign prod  = mul_a * mul_b;

    assign mod_x    = {r_rem, r_v[63:56]};
    assign mod_prod = mod_x * RECIP_MUL;
    assign mod_q    = mod_prod[RECIP_SHIFT +: 8];
    assign mod_r    = mod_x - 15'(mod_q * KEEP_SCALE);

    assign glitch = (r_rem >= KEEP_LIMIT);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            MS_IDLE:  if (!i_q_empty) n_state = MS_MUL;
            MS_MUL:   if (r_step == 2'd2) n_state = MS_SHIFT;
            MS_SHIFT: n_state = r_phase ? MS_MOD : MS_MUL;
            MS_MOD:   if (r_mod_cnt == 3'd7) n_state = MS_DONE;
            MS_DONE:  if (!r_out_vld || !i_stall) n_state = MS_IDLE;
            default:  n_state = MS_IDLE;
        endcase
    end

    always_comb begin
        o_pop    = (r_state == MS_IDLE) && !i_q_empty;
        load_out = (r_state == MS_DONE) && (!r_out_vld || !i_stall);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= MS_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step    <= '0;
            r_phase   <= 1'b0;
            r_mod_cnt <= '0;
        end else begin
            unique case (r_state)
                MS_IDLE: begin
                    r_step  <= '0;
                    r_phase <= 1'b0;
                end
                MS_MUL: begin
                    r_step <= (r_step == 2'd2) ? 2'd0 : r_step + 1'b1;
                end
                MS_SHIFT: begin
                    r_phase   <= 1'b1;
                    r_mod_cnt <= '0;
                end
                MS_MOD: begin
                    r_mod_cnt <= r_mod_cnt + 1'b1;
                end
                default: begin
                    r_step <= '0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            MS_IDLE: begin
                if (o_pop) begin
                    r_z     <= i_work.counter ^ (i_work.counter >> 30);
                    r_glyph <= i_work.clean_glyph;
                    r_eof   <= i_work.end_of_frame;
                end
            end
            MS_MUL: begin
                if (r_step == 2'd0) begin
                    r_acc <= prod;
                end else begin
                    r_acc[63:32] <= r_acc[63:32] + prod[31:0];
                end
            end
            MS_SHIFT: begin
                if (r_phase) begin
                    r_v   <= r_acc ^ (r_acc >> 31);
                    r_pal <= r_acc[3:0] ^ r_acc[34:31];
                    r_rem <= '0;
                end else begin
                    r_z <= r_acc ^ (r_acc >> 27);
                end
            end
            MS_MOD: begin
                // most significant byte first
                r_rem <= mod_r[6:0];
                r_v   <= r_v << 8;
            end
            default: begin
                r_rem <= r_rem;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_out.out_glyph    <= glitch ? palette(r_pal) : r_glyph;
            r_out.glitched     <= glitch;
            r_out.end_of_frame <= r_eof;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (load_out) begin
            r_out_vld <= 1'b1;
        end else if (!i_stall) begin
            r_out_vld <= 1'b0;
        end
    end

    assign o_valid = r_out_vld;
    assign o_data  = r_out;

endmodule

### rtl/core/splitmix_glitch_glyph_stream.sv
// Glitch glyph stream, top level: one glyph cell in, one (possibly replaced)
// glyph out. Depends on sgg_pkg, sgg_front, sgg_queue and sgg_mix_back.
//
// Input channel: i_valid / i_data / o_stall carry one cell per transfer
// (clean glyph and restart flag) in row-major order, frame after frame.
// Output channel: o_valid / o_data / i_stall carry one result per cell:
// the glyph, a glitched flag and an end-of-frame flag.
// Config: i_cfg_we writes the seed word (index 0) or agent_index (index 1);
// the generator picks up new values at the next restart or period wrap.
//
// The front steps the 64-bit counter and cell position in the transfer
// cycle and pushes into a four-entry queue. The mixer works on one cell at
// a time: it pops the queue, forms two 64-bit products from three passes
// each through one 32x32 multiplier with a shift/xor step after each, runs
// eight byte steps of the remainder by 100, and loads the output register;
// it takes no new cell from the queue until that load is done.
// A stalled output holds its result; the mixer then finishes one more cell
// and the queue takes four, after which o_stall rises.
// Reset (synchronous, active low) zeroes the registers, counter and position.
module splitmix_glitch_glyph_stream
    import sgg_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    input  logic                  i_valid,
    input  t_in_item              i_data,
    output logic                  o_stall,
    output logic                  o_valid,
    output t_out_item             o_data,
    input  logic                  i_stall
);

    logic  q_push;
    logic  q_pop;
    logic  q_full;
    logic  q_empty;
    t_work q_wdata;
    t_work q_rdata;

    sgg_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .i_valid     (i_valid),
        .i_data      (i_data),
        .o_stall     (o_stall),
        .i_q_full    (q_full),
        .o_push      (q_push),
        .o_work      (q_wdata)
    );

    sgg_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_wdata (q_wdata),
        .i_pop   (q_pop),
        .o_rdata (q_rdata),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    sgg_mix_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_empty (q_empty),
        .i_work    (q_rdata),
        .o_pop     (q_pop),
        .o_valid   (o_valid),
        .o_data    (o_data),
        .i_stall   (i_stall)
    );

endmodule
